// File: src/matrix_inverse_cofactor_assert.svh
// ----------------------------------------------------------------------------
// matrix_inverse_cofactor_assert.svh
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_COFACTOR_ASSERT_SVH
`define MATRIX_INVERSE_COFACTOR_ASSERT_SVH

// same-cycle implication
`define MINV_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("minv assertion failed");

// next-cycle implication
`define MINV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("minv assertion failed");

`endif

// File: src/minv_pkg.sv
// ----------------------------------------------------------------------------
// minv_pkg
// Shared widths, state type and index helper for the matrix inverse block.
// ----------------------------------------------------------------------------
package minv_pkg;

  localparam int unsigned ElemW      = 32;
  localparam int unsigned AccW       = 64;
  localparam int unsigned StoreDepth = 16;
  localparam int unsigned AddrW      = 4;
  localparam int unsigned ThrW       = 17;
  localparam logic [ThrW-1:0] ThrReset = 17'd7;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CRD,
    ST_CMUL,
    ST_CWR,
    ST_DRD,
    ST_DMUL,
    ST_CHK,
    ST_ORD,
    ST_ODIV
  } state_e;

  typedef enum logic [1:0] {
    MP_AD,
    MP_BC,
    MP_EM
  } mul_ph_e;

  // k-th index of 0..3 when index x is left out
  function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] x);
    return (k < x) ? k : k + 2'd1;
  endfunction

endpackage

// File: src/matrix_inverse_cofactor.sv
// ----------------------------------------------------------------------------
// matrix_inverse_cofactor
// At size 4, 16 elements are loaded, then the block computes 16 cofactors on
// the shared multiplier, a 4-term determinant and, unless the matrix is
// singular, 16 divides in the divider. Busy is high from the last element to
// the last result, and no new element is accepted while busy.
// Reset: load count to zero, threshold to 7; store contents are not cleared.
// ----------------------------------------------------------------------------
module matrix_inverse_cofactor #(
  parameter int unsigned MATRIX_SIZE = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [minv_pkg::ElemW-1:0] element_i,
  input  logic                              thr_we_i,
  input  logic [minv_pkg::ThrW-1:0]         thr_i,
  output logic                              valid_o,
  output logic signed [minv_pkg::ElemW-1:0] inverse_element_o,
  output logic                              singular_o,
  output logic                              last_o
);
  import minv_pkg::*;

  localparam int unsigned Cells    = MATRIX_SIZE * MATRIX_SIZE;
  localparam int unsigned NumTerms = 2 * MATRIX_SIZE - 5;
  localparam int unsigned NumReads = (MATRIX_SIZE == 4) ? 5 : 4;
  localparam bit          Big      = (MATRIX_SIZE == 4);
  localparam logic [1:0]       LastIdx  = 2'(MATRIX_SIZE - 1);
  localparam logic [1:0]       LastTerm = 2'(NumTerms - 1);
  localparam logic [2:0]       LastRead = 3'(NumReads - 1);
  localparam logic [AddrW-1:0] LastCell = AddrW'(Cells - 1);
  localparam logic [1:0]       RowLo    = Big ? 2'd1 : 2'd0;
  localparam logic [1:0]       RowHi    = Big ? 2'd2 : 2'd1;
  localparam logic [2:0] SlotA = 3'd0;
  localparam logic [2:0] SlotD = 3'd1;
  localparam logic [2:0] SlotB = 3'd2;
  localparam logic [2:0] SlotC = 3'd3;
  localparam logic [2:0] SlotE = 3'd4;

  function automatic logic [AddrW-1:0] cell_addr(input logic [1:0] r, input logic [1:0] c);
    return AddrW'(r * MATRIX_SIZE + c);
  endfunction

  state_e           state_q, state_d;
  mul_ph_e          mph_q;
  logic [AddrW-1:0] load_q;
  logic [ThrW-1:0]  thr_q;
  logic [1:0]       ri_q, ci_q, ti_q;
  logic [2:0]       rd_q;
  logic             cap_v_q;
  logic [2:0]       cap_slot_q;
  logic             iss_q;
  logic [ElemW-1:0] op_q [NumReads];
  logic [AccW-1:0]  t1_q, mv_q, acc_q, det_q;
  logic             valid_q, sing_q, last_q;
  logic signed [ElemW-1:0] inv_q;

  logic             accept;
  logic [AddrW-1:0] mat_raddr, cof_raddr;
  logic [ElemW-1:0] mat_rd;
  logic [AccW-1:0]  cof_rd, cof_val;
  logic [1:0]       r0, r1, r2, x0, x1, ce;
  logic             mul_start, mul_done, div_start, div_done;
  logic signed [ElemW-1:0] mul_e;
  logic [AccW-1:0]  mul_m, mul_p;
  logic signed [ElemW-1:0] div_q;
  logic [AccW-1:0]  m_diff, m_term, acc_sum, det_mag;
  logic             is_sing, term_end, cell_last, cof_we;
  logic             emit, emit_sing, emit_last;

  assign accept = start && !busy;

  // ---------------- storage ----------------
  minv_ram #(.Width(ElemW), .Depth(StoreDepth)) u_mat (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (load_q),
    .wdata_i (element_i),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rd)
  );

  minv_ram #(.Width(AccW), .Depth(StoreDepth)) u_cof (
    .clk_i   (clk_i),
    .we_i    (cof_we),
    .waddr_i (cell_addr(ri_q, ci_q)),
    .wdata_i (cof_val),
    .raddr_i (cof_raddr),
    .rdata_o (cof_rd)
  );

  minv_qmul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_e),
    .m_i     (mul_m),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  minv_qdiv u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (cof_rd),
    .den_i   (det_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // ---------------- index generation ----------------
  // cofactor (ri, ci), term ti: e from the first remaining row,
  // 2x2 minor from the other two rows and remaining columns
  assign r0 = skip_idx(2'd0, ri_q);
  assign r1 = skip_idx(RowLo, ri_q);
  assign r2 = skip_idx(RowHi, ri_q);
  assign x0 = Big ? skip_idx(skip_idx(2'd0, ti_q), ci_q) : skip_idx(2'd0, ci_q);
  assign x1 = Big ? skip_idx(skip_idx(2'd1, ti_q), ci_q) : skip_idx(2'd1, ci_q);
  assign ce = skip_idx(ti_q, ci_q);

  always_comb begin
    mat_raddr = '0;
    unique case (state_q)
      ST_CRD: begin
        unique case (rd_q)
          SlotA:   mat_raddr = cell_addr(r1, x0);
          SlotD:   mat_raddr = cell_addr(r2, x1);
          SlotB:   mat_raddr = cell_addr(r1, x1);
          SlotC:   mat_raddr = cell_addr(r2, x0);
          default: mat_raddr = cell_addr(r0, ce);
        endcase
      end
      ST_DRD, ST_DMUL: mat_raddr = AddrW'(ti_q);
      default:         mat_raddr = '0;
    endcase
  end

  always_comb begin
    unique case (state_q)
      ST_DRD, ST_DMUL: cof_raddr = AddrW'(ti_q);
      ST_ORD, ST_ODIV: cof_raddr = cell_addr(ci_q, ri_q);  // transposed
      default:         cof_raddr = '0;
    endcase
  end

  always_comb begin
    if (state_q == ST_DMUL) begin
      mul_e = mat_rd;
      mul_m = cof_rd;
    end else begin
      unique case (mph_q)
        MP_AD: begin
          mul_e = op_q[SlotA];
          mul_m = {{32{op_q[SlotD][ElemW-1]}}, op_q[SlotD]};
        end
        MP_BC: begin
          mul_e = op_q[SlotB];
          mul_m = {{32{op_q[SlotC][ElemW-1]}}, op_q[SlotC]};
        end
        default: begin
          mul_e = op_q[SlotE];
          mul_m = mv_q;
        end
      endcase
    end
  end

  // ---------------- datapath terms ----------------
  assign m_diff   = t1_q - mul_p;
  assign m_term   = ti_q[0] ? -m_diff : m_diff;
  assign acc_sum  = ((ti_q == 2'd0) ? '0 : acc_q) + mul_p;
  assign cof_val  = (ri_q[0] ^ ci_q[0]) ? -acc_q : acc_q;
  assign det_mag  = det_q[AccW-1] ? -det_q : det_q;
  assign is_sing  = (det_q == '0) || (det_mag < {{(AccW-ThrW){1'b0}}, thr_q});
  assign term_end = (mph_q == MP_EM) || (!Big && (mph_q == MP_BC));
  assign cell_last = (ri_q == LastIdx) && (ci_q == LastIdx);

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (accept && (load_q == LastCell)) state_d = ST_CRD;
      ST_CRD:  if (rd_q == LastRead) state_d = ST_CMUL;
      ST_CMUL: begin
        if (mul_done && term_end) begin
          state_d = (ti_q == LastTerm) ? ST_CWR : ST_CRD;
        end
      end
      ST_CWR:  state_d = cell_last ? ST_DRD : ST_CRD;
      ST_DRD:  state_d = ST_DMUL;
      ST_DMUL: if (mul_done) state_d = (ti_q == LastIdx) ? ST_CHK : ST_DRD;
      ST_CHK:  state_d = is_sing ? ST_LOAD : ST_ORD;
      ST_ORD:  state_d = ST_ODIV;
      ST_ODIV: if (div_done) state_d = cell_last ? ST_LOAD : ST_ORD;
      default: state_d = ST_LOAD;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    busy      = (state_q != ST_LOAD);
    mul_start = ((state_q == ST_CMUL) || (state_q == ST_DMUL)) && !iss_q;
    div_start = (state_q == ST_ODIV) && !iss_q;
    cof_we    = (state_q == ST_CWR);
    emit      = 1'b0;
    emit_sing = 1'b0;
    emit_last = 1'b0;
    if ((state_q == ST_CHK) && is_sing) begin
      emit      = 1'b1;
      emit_sing = 1'b1;
      emit_last = 1'b1;
    end else if ((state_q == ST_ODIV) && div_done) begin
      emit      = 1'b1;
      emit_last = cell_last;
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      mph_q      <= MP_AD;
      load_q     <= '0;
      thr_q      <= ThrReset;
      ri_q       <= '0;
      ci_q       <= '0;
      ti_q       <= '0;
      rd_q       <= '0;
      cap_v_q    <= 1'b0;
      cap_slot_q <= '0;
      iss_q      <= 1'b0;
      valid_q    <= 1'b0;
      sing_q     <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cap_v_q    <= (state_q == ST_CRD);
      cap_slot_q <= rd_q;
      valid_q    <= emit;
      if (emit) begin
        sing_q <= emit_sing;
        last_q <= emit_last;
      end
      if (thr_we_i) begin
        thr_q <= thr_i;
      end
      if (accept) begin
        load_q <= (load_q == LastCell) ? '0 : load_q + 1'b1;
      end
      if (mul_start || div_start) begin
        iss_q <= 1'b1;
      end else if (mul_done || div_done) begin
        iss_q <= 1'b0;
      end

      unique case (state_q)
        ST_LOAD: begin
          ri_q  <= '0;
          ci_q  <= '0;
          ti_q  <= '0;
          rd_q  <= '0;
          mph_q <= MP_AD;
        end
        ST_CRD: begin
          rd_q <= (rd_q == LastRead) ? '0 : rd_q + 3'd1;
        end
        ST_CMUL: begin
          if (mul_done) begin
            if (term_end) begin
              mph_q <= MP_AD;
              ti_q  <= (ti_q == LastTerm) ? 2'd0 : ti_q + 2'd1;
            end else begin
              mph_q <= (mph_q == MP_AD) ? MP_BC : MP_EM;
            end
          end
        end
        ST_CWR: begin
          if (ci_q == LastIdx) begin
            ci_q <= '0;
            ri_q <= (ri_q == LastIdx) ? 2'd0 : ri_q + 2'd1;
          end else begin
            ci_q <= ci_q + 2'd1;
          end
        end
        ST_DMUL: begin
          if (mul_done) begin
            ti_q <= (ti_q == LastIdx) ? 2'd0 : ti_q + 2'd1;
          end
        end
        ST_ODIV: begin
          if (div_done) begin
            if (ci_q == LastIdx) begin
              ci_q <= '0;
              ri_q <= (ri_q == LastIdx) ? 2'd0 : ri_q + 2'd1;
            end else begin
              ci_q <= ci_q + 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (cap_v_q) begin
      op_q[cap_slot_q] <= mat_rd;
    end
    if ((state_q == ST_CMUL) && mul_done) begin
      unique case (mph_q)
        MP_AD: t1_q <= mul_p;
        MP_BC: begin
          if (Big) begin
            mv_q <= m_term;
          end else begin
            acc_q <= m_term;
          end
        end
        default: acc_q <= acc_sum;
      endcase
    end
    if ((state_q == ST_DMUL) && mul_done) begin
      acc_q <= acc_sum;
      if (ti_q == LastIdx) begin
        det_q <= acc_sum;
      end
    end
    if (emit) begin
      inv_q <= emit_sing ? '0 : div_q;
    end
  end

  assign valid_o           = valid_q;
  assign inverse_element_o = inv_q;
  assign singular_o        = sing_q;
  assign last_o            = last_q;

endmodule

// File: src/minv_ram.sv
// ----------------------------------------------------------------------------
// minv_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module minv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/minv_qmul.sv
// ----------------------------------------------------------------------------
// minv_qmul
// Q16.16 multiply of a 32-bit element by a 64-bit value, floored, mod 2^64.
// One 33x33 multiplier used over three partial products.
// ----------------------------------------------------------------------------
module minv_qmul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [minv_pkg::ElemW-1:0]   a_i,
  input  logic [minv_pkg::AccW-1:0]           m_i,
  output logic                                done_o,
  output logic [minv_pkg::AccW-1:0]           p_o
);
  import minv_pkg::*;

  localparam logic [1:0] PhLo   = 2'd0;
  localparam logic [1:0] PhMid  = 2'd1;
  localparam logic [1:0] PhHi   = 2'd2;
  localparam logic [1:0] PhLast = 2'd3;

  logic signed [ElemW-1:0] e_q;
  logic [AccW-1:0]         m_q;
  logic                    run_q;
  logic [1:0]              ph_q;
  logic                    done_q;
  logic signed [65:0]      prod_q;
  logic [AccW-1:0]         acc_q;
  logic signed [32:0]      opb;
  logic signed [65:0]      prod;

  always_comb begin
    unique case (ph_q)
      PhLo:    opb = {17'b0, m_q[15:0]};
      PhMid:   opb = {1'b0, m_q[47:16]};
      default: opb = {{17{m_q[63]}}, m_q[63:48]};
    endcase
  end

  assign prod = $signed({e_q[ElemW-1], e_q}) * opb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      ph_q   <= PhLo;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && (ph_q == PhLast);
      if (start_i) begin
        run_q <= 1'b1;
        ph_q  <= PhLo;
      end else if (run_q) begin
        ph_q <= ph_q + 2'd1;
        if (ph_q == PhLast) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      e_q <= a_i;
      m_q <= m_i;
    end
    if (run_q) begin
      unique case (ph_q)
        PhLo: begin
          prod_q <= prod;
        end
        PhMid: begin
          // floor of e * low 16 bits, shifted down
          acc_q  <= {{32{prod_q[47]}}, prod_q[47:16]};
          prod_q <= prod;
        end
        PhHi: begin
          acc_q  <= acc_q + prod_q[63:0];
          prod_q <= prod;
        end
        default: begin
          acc_q <= acc_q + {prod_q[31:0], 32'b0};
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// File: src/minv_qdiv.sv
// ----------------------------------------------------------------------------
// minv_qdiv
// Q16.16 divide (num * 2^16) / den, truncated toward zero, saturated.
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module minv_qdiv (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [minv_pkg::AccW-1:0]         num_i,
  input  logic [minv_pkg::AccW-1:0]         den_i,
  output logic                              done_o,
  output logic signed [minv_pkg::ElemW-1:0] q_o
);
  import minv_pkg::*;

  localparam int unsigned QBits = ElemW - 1;
  localparam logic [4:0] LastStep = 5'(QBits - 1);

  logic             run_q;
  logic             setup_q;
  logic             done_q;
  logic [4:0]       cnt_q;
  logic             neg_q;
  logic             ov_q;
  logic [AccW-1:0]  an_q;
  logic [AccW-1:0]  ad_q;
  logic [AccW-1:0]  rem_q;
  logic [QBits-1:0] low_q;
  logic [QBits-1:0] quo_q;
  logic [AccW:0]    trial;
  logic [AccW:0]    diff;
  logic             ge;

  assign trial = {rem_q, low_q[QBits-1]};
  assign diff  = trial - {1'b0, ad_q};
  assign ge    = trial >= {1'b0, ad_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      setup_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q  <= run_q && (cnt_q == LastStep);
      setup_q <= start_i;
      if (setup_q) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == LastStep) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[AccW-1] ^ den_i[AccW-1];
      an_q  <= num_i[AccW-1] ? -num_i : num_i;
      ad_q  <= den_i[AccW-1] ? -den_i : den_i;
    end
    if (setup_q) begin
      // quotient reaches 2^31 exactly when |num| >= |den| * 2^15
      ov_q  <= {15'b0, an_q} >= {ad_q, 15'b0};
      rem_q <= {15'b0, an_q[AccW-1:15]};
      low_q <= {an_q[14:0], 16'b0};
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= ge ? diff[AccW-1:0] : trial[AccW-1:0];
      quo_q <= {quo_q[QBits-2:0], ge};
      low_q <= {low_q[QBits-2:0], 1'b0};
    end
  end

  always_comb begin
    if (ov_q) begin
      q_o = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (neg_q) begin
      q_o = -$signed({1'b0, quo_q});
    end else begin
      q_o = $signed({1'b0, quo_q});
    end
  end

  assign done_o = done_q;

endmodule

// File: src/minv_checker.sv
// ----------------------------------------------------------------------------
// minv_sva
// Port-level checks on the result sequence of the matrix inverse block.
// ----------------------------------------------------------------------------
`include "matrix_inverse_cofactor_assert.svh"

module minv_sva (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic signed [minv_pkg::ElemW-1:0] element_i,
  input logic                              thr_we_i,
  input logic [minv_pkg::ThrW-1:0]         thr_i,
  input logic                              valid_o,
  input logic signed [minv_pkg::ElemW-1:0] inverse_element_o,
  input logic                              singular_o,
  input logic                              last_o
);

  // a singular answer is a single zero result
  `MINV_ASSERT(a_sing_last, valid_o && singular_o, last_o && (inverse_element_o == '0))
  // the block goes idle only with the last result of a matrix
  `MINV_ASSERT(a_fall_on_last, $fell(busy), valid_o && last_o)
  `MINV_ASSERT(a_last_idle, valid_o && last_o, !busy)
  // more results follow a non-final one, never back to back
  `MINV_ASSERT_NEXT(a_mid_busy, valid_o && !last_o, busy && !valid_o)

endmodule

bind matrix_inverse_cofactor minv_sva u_minv_sva (.*);

// File: tb/minv_checker.sv
// ----------------------------------------------------------------------------
// minv_checker
// Watches the element and result channels of the matrix inverse block.
// It predicts each inverse from the loaded matrix and compares the results
// in order.
// ----------------------------------------------------------------------------
module minv_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic signed [minv_pkg::ElemW-1:0] element_i,
  input  logic                              thr_we_i,
  input  logic [minv_pkg::ThrW-1:0]         thr_i,
  input  logic                              valid_i,
  input  logic signed [minv_pkg::ElemW-1:0] inverse_element_i,
  input  logic                              singular_i,
  input  logic                              last_i,
  output int                                errors_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] value;
    logic        singular;
    logic        last;
  } inv_result_t;

  inv_result_t                 expected_inverse_q[$];
  logic [31:0]                 mat[16];
  logic [3:0]                  fill_cnt;
  logic [minv_pkg::ThrW-1:0]   threshold;

  function automatic logic [63:0] asr16(input logic [63:0] u);
    return $signed(u) >>> 16;
  endfunction

  function automatic logic [63:0] qmul(input logic [63:0] e, input logic [63:0] m);
    logic [63:0] hi, lo, p;
    hi = asr16(m);
    lo = m & 64'hFFFF;
    p  = e * lo;
    return e * hi + asr16(p);
  endfunction

  function automatic logic [63:0] mat_at(input int r, input int c);
    logic [31:0] v;
    v = mat[(r * 4 + c) & 15];
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] det2(input int r0, input int r1,
                                       input int c0, input int c1);
    return qmul(mat_at(r0, c0), mat_at(r1, c1)) - qmul(mat_at(r0, c1), mat_at(r1, c0));
  endfunction

  // expansion along the first listed row of a 3x3 minor
  function automatic logic [63:0] det3(input int r0, input int r1, input int r2,
                                       input int c0, input int c1, input int c2);
    logic [63:0] m, acc;
    int cs[3];
    cs[0] = c0; cs[1] = c1; cs[2] = c2;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      case (i)
        0: m = det2(r1, r2, c1, c2);
        1: m = det2(r1, r2, c0, c2);
        default: m = det2(r1, r2, c0, c1);
      endcase
      if (i & 1) m = 64'd0 - m;
      acc += qmul(mat_at(r0, cs[i]), m);
    end
    return acc;
  endfunction

  function automatic logic [63:0] cofactor(input int row, input int col);
    int rs[3], cs[3];
    int nr, nc;
    logic [63:0] m;
    nr = 0; nc = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != row) begin rs[nr] = i; nr++; end
      if (i != col) begin cs[nc] = i; nc++; end
    end
    m = det3(rs[0], rs[1], rs[2], cs[0], cs[1], cs[2]);
    if ((row + col) & 1) m = 64'd0 - m;
    return m;
  endfunction

  function automatic logic [63:0] determinant();
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < 4; i++) acc += qmul(mat_at(0, i), cofactor(0, i));
    return acc;
  endfunction

  // (c << 16) / d toward zero, saturated to 32 bits
  function automatic logic [31:0] qdiv(input logic [63:0] c, input logic [63:0] d);
    logic        neg;
    logic [63:0] ac, ad, qi, rem, mag;
    neg = c[63] ^ d[63];
    ac  = c[63] ? 64'd0 - c : c;
    ad  = d[63] ? 64'd0 - d : d;
    qi  = ac / ad;
    rem = ac % ad;
    if (qi >= 64'd32768) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag = qi << 16;
    for (int b = 0; b < 16; b++) begin
      rem = rem << 1;
      if (rem >= ad) begin
        rem = rem - ad;
        mag[15 - b] = 1'b1;
      end
    end
    if (neg) begin
      if (mag >= 64'h8000_0000) return 32'h8000_0000;
      return 32'd0 - mag[31:0];
    end
    if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  task automatic predict_inverse();
    logic [63:0] det, mag;
    inv_result_t res;
    det = determinant();
    mag = det[63] ? 64'd0 - det : det;
    if (det == 0 || mag < {47'd0, threshold}) begin
      res = '{value: '0, singular: 1'b1, last: 1'b1};
      expected_inverse_q.push_back(res);
    end else begin
      for (int k = 0; k < 16; k++) begin
        res.value    = qdiv(cofactor(k % 4, k / 4), det);
        res.singular = 1'b0;
        res.last     = (k == 15);
        expected_inverse_q.push_back(res);
      end
    end
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    inv_result_t exp_res;
    if (!rst_ni) begin
      fill_cnt  <= '0;
      threshold <= minv_pkg::ThrReset;
      errors_o  <= 0;
      expected_inverse_q.delete();
    end else begin
      if (thr_we_i) threshold <= thr_i;
      if (valid_i) begin
        if (expected_inverse_q.size() == 0) begin
          $display("%0t: unexpected result inv %h sing %b last %b", $time,
                   inverse_element_i, singular_i, last_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_res = expected_inverse_q.pop_front();
          if (exp_res.value !== inverse_element_i || exp_res.singular !== singular_i
              || exp_res.last !== last_i) begin
            $display("%0t: mismatch exp inv %h sing %b last %b, act inv %h sing %b last %b",
                     $time, exp_res.value, exp_res.singular, exp_res.last,
                     inverse_element_i, singular_i, last_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        mat[fill_cnt] = element_i;
        fill_cnt <= fill_cnt + 4'd1;
        if (fill_cnt == 4'd15) predict_inverse();
      end
    end
  end

  assign pending_o = expected_inverse_q.size();

endmodule

// File: tb/tb_matrix_inverse_cofactor.sv
// ----------------------------------------------------------------------------
// tb_matrix_inverse_cofactor
// Feeds matrices to the inverse block under several thresholds and sender
// idle rates; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_matrix_inverse_cofactor;
  timeunit 1ns;
  timeprecision 1ps;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic signed [minv_pkg::ElemW-1:0] element_i = '0;
  logic                              thr_we_i = 1'b0;
  logic [minv_pkg::ThrW-1:0]         thr_i = '0;
  logic                              valid_o;
  logic signed [minv_pkg::ElemW-1:0] inverse_element_o;
  logic                              singular_o;
  logic                              last_o;
  int                                errors, pending;
  int                                idle_pct = 0;
  int                                quiet_cycles = 0;

  localparam int WatchdogLimit = 20000;

  matrix_inverse_cofactor #(.MATRIX_SIZE(4)) dut (.*);

  minv_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .element_i,
    .thr_we_i, .thr_i, .valid_i(valid_o), .inverse_element_i(inverse_element_o),
    .singular_i(singular_o), .last_i(last_o), .errors_o(errors), .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // one element request; busy is sampled mid-cycle so acceptance is race free
  task automatic send_element(input logic [31:0] v);
    logic ok;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start     <= 1'b1;
    element_i <= v;
    do begin
      @(negedge clk_i);
      ok = !busy;
      @(posedge clk_i);
    end while (!ok);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [minv_pkg::ThrW-1:0] v);
    thr_we_i <= 1'b1;
    thr_i    <= v;
    @(posedge clk_i);
    thr_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_small(input int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  task automatic send_matrix(input int kind);
    logic [31:0] m[16];
    int src;
    for (int k = 0; k < 16; k++) begin
      case (kind)
        0: m[k] = (k % 5 == 0) ? 32'h0001_0000 : 32'h0;             // identity
        1: m[k] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000; // extremes
        2: m[k] = $urandom();                                        // full range
        3: m[k] = (k % 5 == 0) ? rand_small(8 << 16) + 32'h0005_0000
                               : rand_small(1 << 16);                // well conditioned
        4: m[k] = (k % 5 == 0) ? 32'h0001_0000 : 32'h0;             // near threshold
        default: m[k] = rand_small(4 << 16);                         // singular
      endcase
    end
    if (kind == 4) m[5 * $urandom_range(3)] = rand_small(70000);
    if (kind >= 5) begin
      src = $urandom_range(3);
      for (int c = 0; c < 4; c++) m[((src + 1) % 4) * 4 + c] = m[src * 4 + c];
    end
    foreach (m[k]) send_element(m[k]);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_matrix(0);
    send_matrix(1);
    drain();

    for (int n = 0; n < 27; n++) begin
      case (n % 6)
        0: write_threshold(17'd0);
        1: write_threshold(17'd65536);
        2: write_threshold(17'd1);
        3: write_threshold(17'd7);
        default: write_threshold(17'($urandom_range(65536)));
      endcase
      case ((n / 7) % 4)
        0: idle_pct = 0;
        1: idle_pct = 88;
        2: idle_pct = 33;
        default: idle_pct = 0;
      endcase
      send_matrix(2 + (n % 5));
      drain();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/minv_pkg.sv
src/minv_ram.sv
src/minv_qmul.sv
src/minv_qdiv.sv
src/matrix_inverse_cofactor.sv
src/minv_checker.sv
tb/minv_checker.sv
tb/tb_matrix_inverse_cofactor.sv
